// ----- hw/rtl/go_back_n_sender_window_unit_defines.svh -----
// assertion helpers shared by the window unit modules
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_DEFINES_SVH

// invariant that holds at every edge out of reset
`define GBN_ASSERT_ALWAYS(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// same-cycle implication
`define GBN_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GBN_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gbn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gbn_pkg;

   localparam int DATA_BYTES   = 1024;
   localparam int WINDOW_SLOTS = 64;
   localparam int MAX_PACKETS  = 16384;

   localparam int DATA_SHIFT = $clog2(DATA_BYTES);
   localparam int SLOT_W     = $clog2(WINDOW_SLOTS);

   localparam int MODE_W     = 2;
   localparam int SIZE_W     = 24;
   localparam int PKT_W      = 14;
   localparam int CNT_W      = 15;
   localparam int LEN_W      = 11;
   localparam int SPAN_W     = 6;
   localparam int TMO_W      = 16;
   localparam int TIME_W     = 32;
   localparam int DL_W       = 33;
   localparam int OFF_W      = SIZE_W + 1;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [SPAN_W-1:0] SPAN_RESET    = SPAN_W'(3);
   localparam logic [TMO_W-1:0]  TIMEOUT_RESET = TMO_W'(2);
   localparam logic [CNT_W-1:0]  MAX_SPAN      = CNT_W'((2 ** SPAN_W) - 1);

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_SPAN   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_TIMEOUT_TICKS = CSR_IDX_W'(1);

   typedef enum logic [MODE_W-1:0] {
      MODE_REQUEST = 2'd0,
      MODE_ACK     = 2'd1,
      MODE_TICK    = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_TICK_CHECK,
      S_SEND,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CAPTURE,
      CMD_START,
      CMD_SLIDE,
      CMD_TICK,
      CMD_RESEND,
      CMD_SEND,
      CMD_DONE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      mode_type mode;
      logic     ack_in_range;
      logic     ack_final;
      logic     ack_stale;
      logic     can_send;
      logic     more_after;
      logic     timed_out;
      logic     out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ----- hw/rtl/gbn_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gbn_req_if;
   import gbn_pkg::*;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [SIZE_W-1:0] file_size_bytes;
   logic [PKT_W-1:0]  ack_num;

   modport source (output valid, output mode, output file_size_bytes, output ack_num,
                   input ready);
   modport sink (input valid, input mode, input file_size_bytes, input ack_num,
                 output ready);
endinterface

interface gbn_rsp_if;
   import gbn_pkg::*;
   logic             valid;
   logic             ready;
   logic [PKT_W-1:0] packet_id;
   logic [LEN_W-1:0] payload_length;
   logic             end_of_file;
   logic             transfer_done;
   logic             last;

   modport source (output valid, output packet_id, output payload_length,
                   output end_of_file, output transfer_done, output last, input ready);
   modport sink (input valid, input packet_id, input payload_length,
                 input end_of_file, input transfer_done, input last, output ready);
endinterface

interface gbn_csr_if;
   import gbn_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/gbn_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "go_back_n_sender_window_unit_defines.svh"

module gbn_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  gbn_pkg::dp_status_type status,
   output gbn_pkg::dp_cmd_type    cmd
);
   import gbn_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd.op    = CMD_NONE;
      cmd.last  = 1'b0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.op   = CMD_CAPTURE;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            unique case (status.mode)
               MODE_REQUEST: begin
                  cmd.op   = CMD_START;
                  state_in = S_SEND;
               end
               MODE_ACK: begin
                  if (!status.ack_in_range) begin
                     state_in = S_IDLE;
                  end else if (status.ack_final) begin
                     state_in = S_DONE;
                  end else if (status.ack_stale) begin
                     state_in = S_IDLE;
                  end else begin
                     cmd.op   = CMD_SLIDE;
                     state_in = S_SEND;
                  end
               end
               MODE_TICK: begin
                  cmd.op   = CMD_TICK;
                  state_in = S_TICK_CHECK;
               end
               MODE_UNUSED: begin
                  state_in = S_IDLE;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_TICK_CHECK: begin
            // deadline of the base slot was read during the tick cycle
            if (status.timed_out) begin
               cmd.op   = CMD_RESEND;
               state_in = S_SEND;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SEND: begin
            if (!status.can_send) begin
               state_in = S_IDLE;
            end else if (status.out_free) begin
               cmd.op   = CMD_SEND;
               cmd.last = !status.more_after;
               if (!status.more_after) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               cmd.op   = CMD_DONE;
               cmd.last = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   `GBN_ASSERT_NEXT(a_last_send_ends_run, (cmd.op == CMD_SEND) && cmd.last, state_ff == S_IDLE, "send run did not end on its last transaction")
   `GBN_ASSERT_IMPLY(a_send_only_when_allowed, cmd.op == CMD_SEND, status.can_send && status.out_free, "send issued outside the window")

endmodule

`default_nettype wire

// ----- hw/rtl/gbn_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none

`include "go_back_n_sender_window_unit_defines.svh"

module gbn_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  gbn_pkg::dp_cmd_type               cmd,
   output gbn_pkg::dp_status_type            status,
   input  logic [gbn_pkg::MODE_W-1:0]        req_mode,
   input  logic [gbn_pkg::SIZE_W-1:0]        req_file_size_bytes,
   input  logic [gbn_pkg::PKT_W-1:0]         req_ack_num,
   input  logic                              csr_write,
   input  logic [gbn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gbn_pkg::CSR_DATA_W-1:0]    csr_data,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [gbn_pkg::PKT_W-1:0]         rsp_packet_id,
   output logic [gbn_pkg::LEN_W-1:0]         rsp_payload_length,
   output logic                              rsp_end_of_file,
   output logic                              rsp_transfer_done,
   output logic                              rsp_last
);
   import gbn_pkg::*;

   // latched item
   mode_type          mode_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [PKT_W-1:0]  ack_ff;

   // configuration
   logic [SPAN_W-1:0] span_ff, span_in;
   logic [TMO_W-1:0]  tmo_ff, tmo_in;

   // window state
   logic [PKT_W-1:0]        base_ff, base_in;
   logic [CNT_W-1:0]        end_ff, end_in;
   logic [CNT_W-1:0]        next_ff, next_in;
   logic [CNT_W-1:0]        total_ff, total_in;
   logic [SIZE_W-1:0]       bytes_ff, bytes_in;
   logic [TIME_W-1:0]       time_ff, time_in;
   logic [WINDOW_SLOTS-1:0] slot_valid_ff, slot_valid_in;

   // deadline memory, one registered read port at the base slot
   logic [DL_W-1:0] deadline_mem [WINDOW_SLOTS];
   logic [DL_W-1:0] dl_q;
   logic            dl_valid_q;

   // output register
   logic             out_valid_ff, out_valid_in;
   logic [PKT_W-1:0] out_pkt_ff;
   logic [LEN_W-1:0] out_len_ff;
   logic             out_eof_ff;
   logic             out_done_ff;
   logic             out_last_ff;

   logic [OFF_W-1:0]  count_sum;
   logic [OFF_W-1:0]  count_wide;
   logic [CNT_W-1:0]  count_sat;
   logic [OFF_W-1:0]  offset;
   logic [OFF_W-1:0]  left;
   logic [LEN_W-1:0]  send_len;
   logic              send_eof;
   logic [TMO_W-1:0]  tmo_eff;
   logic [DL_W-1:0]   deadline_new;
   logic [CNT_W-1:0]  next_plus;
   logic [PKT_W-1:0]  slide_base;
   logic [CNT_W-1:0]  slide_next;
   logic [SLOT_W-1:0] send_slot;
   logic              emit;

   always_comb begin
      count_sum  = {1'b0, size_ff} + OFF_W'(DATA_BYTES - 1);
      count_wide = count_sum >> DATA_SHIFT;
      count_sat  = (count_wide > OFF_W'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS)
                                                      : count_wide[CNT_W-1:0];
      offset     = OFF_W'(next_ff[PKT_W-1:0]) * OFF_W'(DATA_BYTES);
      left       = (offset < {1'b0, bytes_ff}) ? ({1'b0, bytes_ff} - offset) : '0;
      send_len   = (left >= OFF_W'(DATA_BYTES)) ? LEN_W'(DATA_BYTES) : left[LEN_W-1:0];
      send_eof   = (left <= OFF_W'(DATA_BYTES));
      // a zero timeout behaves as one tick
      tmo_eff      = (tmo_ff == '0) ? TMO_W'(1) : tmo_ff;
      deadline_new = {1'b0, time_ff} + DL_W'(tmo_eff);
      next_plus    = next_ff + CNT_W'(1);
      slide_base   = ack_ff + PKT_W'(1);
      slide_next   = (next_ff < {1'b0, slide_base}) ? {1'b0, slide_base} : next_ff;
      send_slot    = next_ff[SLOT_W-1:0];
      emit         = (cmd.op == CMD_SEND) || (cmd.op == CMD_DONE);
   end

   always_comb begin
      status.mode         = mode_ff;
      status.ack_in_range = (total_ff != '0) && ({1'b0, ack_ff} < total_ff);
      status.ack_final    = ({1'b0, ack_ff} == (total_ff - CNT_W'(1)));
      status.ack_stale    = (ack_ff < base_ff);
      status.can_send     = (next_ff <= end_ff) && (next_ff < total_ff);
      status.more_after   = (next_plus <= end_ff) && (next_plus < total_ff);
      status.timed_out    = (total_ff != '0) && ({1'b0, base_ff} < total_ff) && dl_valid_q
                            && ({1'b0, time_ff} >= dl_q);
      status.out_free     = !out_valid_ff || rsp_ready;
   end

   always_comb begin
      span_in       = span_ff;
      tmo_in        = tmo_ff;
      base_in       = base_ff;
      end_in        = end_ff;
      next_in       = next_ff;
      total_in      = total_ff;
      bytes_in      = bytes_ff;
      time_in       = time_ff;
      slot_valid_in = slot_valid_ff;

      if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW_SPAN:   span_in = csr_data[SPAN_W-1:0];
            REG_TIMEOUT_TICKS: tmo_in  = csr_data[TMO_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (cmd.op)
         CMD_START: begin
            bytes_in      = size_ff;
            total_in      = count_sat;
            base_in       = '0;
            next_in       = '0;
            end_in        = CNT_W'(span_ff);
            slot_valid_in = '0;
         end
         CMD_SLIDE: begin
            // end moves by the same amount as the base
            end_in  = end_ff + ({1'b0, ack_ff} - {1'b0, base_ff}) + CNT_W'(1);
            base_in = slide_base;
            next_in = slide_next;
         end
         CMD_TICK: begin
            time_in = time_ff + TIME_W'(1);
         end
         CMD_RESEND: begin
            next_in = {1'b0, base_ff};
            end_in  = {1'b0, base_ff} + CNT_W'(span_ff);
         end
         CMD_SEND: begin
            next_in                  = next_plus;
            slot_valid_in[send_slot] = 1'b1;
         end
         CMD_DONE: begin
            slot_valid_in = '0;
         end
         CMD_NONE, CMD_CAPTURE: begin
         end
         default: begin
         end
      endcase

      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         span_ff       <= SPAN_RESET;
         tmo_ff        <= TIMEOUT_RESET;
         base_ff       <= '0;
         end_ff        <= CNT_W'(SPAN_RESET);
         next_ff       <= '0;
         total_ff      <= '0;
         bytes_ff      <= '0;
         time_ff       <= '0;
         slot_valid_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         span_ff       <= span_in;
         tmo_ff        <= tmo_in;
         base_ff       <= base_in;
         end_ff        <= end_in;
         next_ff       <= next_in;
         total_ff      <= total_in;
         bytes_ff      <= bytes_in;
         time_ff       <= time_in;
         slot_valid_ff <= slot_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_CAPTURE) begin
         mode_ff <= mode_type'(req_mode);
         size_ff <= req_file_size_bytes;
         ack_ff  <= req_ack_num;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == CMD_SEND) begin
         deadline_mem[send_slot] <= deadline_new;
      end
      dl_q       <= deadline_mem[base_ff[SLOT_W-1:0]];
      dl_valid_q <= slot_valid_ff[base_ff[SLOT_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_last_ff <= cmd.last;
         if (cmd.op == CMD_SEND) begin
            out_pkt_ff  <= next_ff[PKT_W-1:0];
            out_len_ff  <= send_len;
            out_eof_ff  <= send_eof;
            out_done_ff <= 1'b0;
         end else begin
            out_pkt_ff  <= '0;
            out_len_ff  <= '0;
            out_eof_ff  <= 1'b0;
            out_done_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_packet_id      = out_pkt_ff;
   assign rsp_payload_length = out_len_ff;
   assign rsp_end_of_file    = out_eof_ff;
   assign rsp_transfer_done  = out_done_ff;
   assign rsp_last           = out_last_ff;

   `GBN_ASSERT_ALWAYS(a_next_not_below_base, next_ff >= {1'b0, base_ff},
                      "next to send fell below window base")
   `GBN_ASSERT_ALWAYS(a_window_span_bound, (end_ff - {1'b0, base_ff}) <= MAX_SPAN,
                      "window wider than the span register allows")
   `GBN_ASSERT_IMPLY(a_emit_into_free_slot, emit, !out_valid_ff || rsp_ready,
                     "output register overwritten before it was taken")

endmodule

`default_nettype wire

// ----- hw/rtl/go_back_n_sender_window_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Go-Back-N sender window. A request (mode 0) starts a transfer of
// file_size_bytes and sends packets 0 up to window_span; an ack (mode 1) slides
// the window and sends what it now admits, or yields a single transfer_done
// transaction on the last packet; a tick (mode 2) advances time and resends the
// whole window from the base when the base deadline has been reached. Items are
// handled one at a time: an accepted item is decided in the EXEC state (a tick
// goes on to TICK_CHECK, as its deadline comes from a registered memory read),
// then send commands are issued while the output register is free. Per-slot
// deadline flags clear at reset, so there is no memory clearing pass. The
// configuration port is always ready and should only be written while the unit
// is idle.
module go_back_n_sender_window_unit (
   input  logic      clock,
   input  logic      reset,
   gbn_req_if.sink   req_chan,
   gbn_rsp_if.source rsp_chan,
   gbn_csr_if.sink   csr_chan
);
   import gbn_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;

   gbn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   gbn_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_chan.mode),
      .req_file_size_bytes (req_chan.file_size_bytes),
      .req_ack_num         (req_chan.ack_num),
      .csr_write           (csr_chan.valid),
      .csr_index           (csr_chan.index),
      .csr_data            (csr_chan.data),
      .rsp_ready           (rsp_chan.ready),
      .rsp_valid           (rsp_chan.valid),
      .rsp_packet_id       (rsp_chan.packet_id),
      .rsp_payload_length  (rsp_chan.payload_length),
      .rsp_end_of_file     (rsp_chan.end_of_file),
      .rsp_transfer_done   (rsp_chan.transfer_done),
      .rsp_last            (rsp_chan.last)
   );

endmodule

`default_nettype wire
